// ===== rtl/core/irr_pkg.sv =====
package irr_pkg;

  // Image geometry limits
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  // Field widths
  localparam int PixW  = 8;
  localparam int DimW  = 12;
  localparam int DataW = 32;
  localparam int AddrW = 4;

  // Derived widths
  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int CntW  = ((ColW > RowW) ? ColW : RowW) + 1;
  localparam int MaxDim = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int AccW  = $clog2(MaxDim * 255 + 1);
  localparam int StepW = $clog2(AccW + 1);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    RegAxis   = 2'd0,
    RegOp     = 2'd1,
    RegWidth  = 2'd2,
    RegHeight = 2'd3
  } reg_idx_e;

  // Reduction operations
  typedef enum logic [1:0] {
    OpSum = 2'd0,
    OpAvg = 2'd1,
    OpMax = 2'd2,
    OpMin = 2'd3
  } reduce_op_e;

  // Axis codes
  localparam logic AxisColumns = 1'b0;
  localparam logic AxisRows    = 1'b1;

endpackage

// ===== rtl/core/irr_pix_if.sv =====
interface irr_pix_if;
  logic                      valid;
  logic                      ready;
  logic [irr_pkg::PixW-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/core/irr_res_if.sv =====
interface irr_res_if;
  logic                      valid;
  logic                      ready;
  logic [irr_pkg::PixW-1:0]  reduced_value;
  logic                      frame_last;

  modport source (output valid, output reduced_value, output frame_last, input ready);
  modport sink   (input valid, input reduced_value, input frame_last, output ready);
endinterface

// ===== rtl/core/image_row_column_reduce_unit.sv =====
// Row / column reduction of an 8-bit single-channel image.
//
// pix_i takes one pixel beat in raster order; res_o gives one result beat
// per reduced row (reduce_axis 1, at each row end) or per column (reduce_axis
// 0, one for each pixel of the last row). frame_last marks the final result
// of the image. The user must write the registers over the APB port only
// while the block idles; the block itself does not enforce this.
// Each pixel reads the column accumulator memory as it is taken (S_IDLE)
// and is combined and written back in S_COMB. A pixel that yields a result
// then goes through S_OUT to the output register, after the bit-serial
// divider (S_DIV) when averaging. The read-modify-write of the single-port
// column memory sets the pixel interval; the divider sets the averaging latency.
//
// Reset clears positions, registers and the output valid flag; the column
// memory is not cleared, as the first row loads it. When the receiver stalls
// the result is held, the next pixel is still taken and worked on, and the
// block waits only when a second result is ready before the first has left.
module image_row_column_reduce_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  irr_pix_if.sink                      pix_i,
  irr_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irr_pkg::AddrW-1:0]    paddr,
  input  logic [irr_pkg::DataW-1:0]    pwdata,
  output logic [irr_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  localparam int ColW  = irr_pkg::ColW;
  localparam int RowW  = irr_pkg::RowW;
  localparam int CntW  = irr_pkg::CntW;
  localparam int AccW  = irr_pkg::AccW;
  localparam int PixW  = irr_pkg::PixW;
  localparam int DimW  = irr_pkg::DimW;
  localparam int StepW = irr_pkg::StepW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMB,
    S_DIV,
    S_OUT
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic                        cfg_axis_q;
  irr_pkg::reduce_op_e         cfg_op_q;
  logic [DimW-1:0]             cfg_width_q;
  logic [DimW-1:0]             cfg_height_q;
  logic                        cfg_wr;
  irr_pkg::reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = irr_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_axis_q   <= irr_pkg::AxisColumns;
      cfg_op_q     <= irr_pkg::OpSum;
      cfg_width_q  <= DimW'(irr_pkg::MaxWidth);
      cfg_height_q <= DimW'(irr_pkg::MaxHeight);
    end else if (cfg_wr) begin
      case (cfg_idx)
        irr_pkg::RegAxis:   cfg_axis_q   <= pwdata[0];
        irr_pkg::RegOp:     cfg_op_q     <= irr_pkg::reduce_op_e'(pwdata[1:0]);
        irr_pkg::RegWidth:  cfg_width_q  <= pwdata[DimW-1:0];
        irr_pkg::RegHeight: cfg_height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      irr_pkg::RegAxis:   prdata = 32'(cfg_axis_q);
      irr_pkg::RegOp:     prdata = 32'(cfg_op_q);
      irr_pkg::RegWidth:  prdata = 32'(cfg_width_q);
      irr_pkg::RegHeight: prdata = 32'(cfg_height_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clamped last column / row, and element counts for the average
  logic [ColW-1:0] col_last;
  logic [RowW-1:0] row_last;
  logic [CntW-1:0] col_cnt;
  logic [CntW-1:0] row_cnt;

  always_comb begin
    if (cfg_width_q == '0) begin
      col_last = '0;
    end else if (32'(cfg_width_q) > irr_pkg::MaxWidth) begin
      col_last = ColW'(irr_pkg::MaxWidth - 1);
    end else begin
      col_last = ColW'(cfg_width_q - DimW'(1));
    end
    if (cfg_height_q == '0) begin
      row_last = '0;
    end else if (32'(cfg_height_q) > irr_pkg::MaxHeight) begin
      row_last = RowW'(irr_pkg::MaxHeight - 1);
    end else begin
      row_last = RowW'(cfg_height_q - DimW'(1));
    end
  end

  assign col_cnt = CntW'(col_last) + CntW'(1);
  assign row_cnt = CntW'(row_last) + CntW'(1);

  // ---------------------------------------------------------------------------
  // Datapath signals
  state_e              state_q;
  logic [ColW-1:0]     col_pos_q;
  logic [RowW-1:0]     row_pos_q;
  logic [AccW-1:0]     row_acc_q;
  logic [PixW-1:0]     px_q;
  logic [ColW-1:0]     idx_q;
  logic                first_q;
  logic                row_end_q;
  logic                last_row_q;
  logic [AccW-1:0]     col_rdata_q;

  logic                in_acc;
  logic                row_end;
  logic                last_row;
  logic                emit;
  logic [AccW-1:0]     acc_old;
  logic [AccW-1:0]     acc_new;
  logic [AccW-1:0]     px_ext;

  // Divider state
  logic [AccW-1:0]     quot_q;
  logic [CntW:0]       rem_q;
  logic [CntW-1:0]     divisor_q;
  logic [StepW-1:0]    step_q;
  logic [CntW:0]       rem_sh;
  logic                div_ge;

  // Output register
  logic                out_valid_q;
  logic [PixW-1:0]     out_value_q;
  logic                out_last_q;
  logic [PixW-1:0]     res_value_q;
  logic                res_last_q;
  logic                out_pop;
  logic                out_free;

  assign pix_i.ready         = (state_q == S_IDLE);
  assign in_acc              = pix_i.valid && pix_i.ready;
  assign res_o.valid         = out_valid_q;
  assign res_o.reduced_value = out_value_q;
  assign res_o.frame_last    = out_last_q;
  assign out_pop             = out_valid_q && res_o.ready;
  assign out_free            = !out_valid_q || res_o.ready;

  assign row_end  = (col_pos_q >= col_last);
  assign last_row = (row_pos_q >= row_last);

  // Column accumulator memory: one write or one read per cycle
  logic [AccW-1:0] col_acc_mem [irr_pkg::MaxWidth];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_rdata_q <= col_acc_mem[col_pos_q];
    end
    if (state_q == S_COMB && cfg_axis_q == irr_pkg::AxisColumns) begin
      col_acc_mem[idx_q] <= acc_new;
    end
  end

  // Combine the pixel into the old accumulator
  assign px_ext  = AccW'(px_q);
  assign acc_old = (cfg_axis_q == irr_pkg::AxisColumns) ? col_rdata_q : row_acc_q;

  always_comb begin
    if (first_q) begin
      acc_new = px_ext;
    end else begin
      case (cfg_op_q)
        irr_pkg::OpSum, irr_pkg::OpAvg: acc_new = acc_old + px_ext;
        irr_pkg::OpMax: acc_new = (acc_old > px_ext) ? acc_old : px_ext;
        irr_pkg::OpMin: acc_new = (acc_old < px_ext) ? acc_old : px_ext;
        default:        acc_new = acc_old;
      endcase
    end
  end

  // A result is due at the last row (columns) or at the row end (rows)
  assign emit = (cfg_axis_q == irr_pkg::AxisColumns) ? last_row_q : row_end_q;

  // Restoring divider step, one quotient bit a cycle
  assign rem_sh = {rem_q[CntW-1:0], quot_q[AccW-1]};
  assign div_ge = (rem_sh >= {1'b0, divisor_q});

  // ---------------------------------------------------------------------------
  // Sequencer, positions and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      row_acc_q   <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_pop && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            px_q       <= pix_i.pixel_in;
            idx_q      <= col_pos_q;
            first_q    <= (cfg_axis_q == irr_pkg::AxisColumns) ? (row_pos_q == '0)
                                                               : (col_pos_q == '0);
            row_end_q  <= row_end;
            last_row_q <= last_row;
            if (row_end) begin
              col_pos_q <= '0;
              row_pos_q <= last_row ? '0 : row_pos_q + RowW'(1);
            end else begin
              col_pos_q <= col_pos_q + ColW'(1);
            end
            state_q <= S_COMB;
          end
        end
        S_COMB: begin
          if (cfg_axis_q == irr_pkg::AxisRows) begin
            row_acc_q <= acc_new;
          end
          res_value_q <= acc_new[PixW-1:0];
          res_last_q  <= (cfg_axis_q == irr_pkg::AxisColumns) ? row_end_q : last_row_q;
          if (!emit) begin
            state_q <= S_IDLE;
          end else if (cfg_op_q == irr_pkg::OpAvg) begin
            quot_q    <= acc_new;
            rem_q     <= '0;
            divisor_q <= (cfg_axis_q == irr_pkg::AxisColumns) ? row_cnt : col_cnt;
            step_q    <= StepW'(AccW);
            state_q   <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          rem_q  <= div_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
          quot_q <= {quot_q[AccW-2:0], div_ge};
          step_q <= step_q - StepW'(1);
          if (step_q == StepW'(1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= (cfg_op_q == irr_pkg::OpAvg) ? quot_q[PixW-1:0] : res_value_q;
            out_last_q  <= res_last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_accept_to_comb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_COMB)
    else $error("accepted pixel did not move to combine");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !res_o.ready) |=> state_q == S_OUT && out_valid_q)
    else $error("pending result overwritten");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end) |=> col_pos_q == '0)
    else $error("column position not cleared at row end");

  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (step_q != '0 && step_q <= StepW'(AccW)))
    else $error("divider step count out of range");

endmodule
